@@ rtl/tcf_pkg.sv @@
// Shared types, constants and tables of the triangular characteristic function block.
package tcf_pkg;

  // Status codes carried with every result.
  localparam logic [1:0] TCF_ST_OK        = 2'd0;
  localparam logic [1:0] TCF_ST_ZERO_ARG  = 2'd1;
  localparam logic [1:0] TCF_ST_BAD_ORDER = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] TCF_REG_LOWER = 2'd0;
  localparam logic [1:0] TCF_REG_PEAK  = 2'd1;
  localparam logic [1:0] TCF_REG_UPPER = 2'd2;

  localparam logic signed [31:0] TCF_LOWER_RST = 32'sd0;
  localparam logic signed [31:0] TCF_PEAK_RST  = 32'sd32768;
  localparam logic signed [31:0] TCF_UPPER_RST = 32'sd65536;

  localparam int TCF_QUEUE_DEPTH = 2;

  // Phase reduction constants in Q32.32.
  localparam logic [34:0] TWO_PI_Q32  = 35'd26986075409;
  localparam logic [34:0] HALF_PI_Q32 = 35'd6746518852;
  localparam int MOD_STEPS = 28;

  localparam int CORDIC_STEPS = 24;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
  localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128
  };

  // Product, magnitude, reduction, wrap, quadrant, rotation and output stages.
  localparam int PH_LAT   = MOD_STEPS + CORDIC_STEPS + 5;
  localparam int DIV_BITS = 63;
  localparam int DIV_LAT  = DIV_BITS + 1;
  localparam int NDIV     = 5;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] c;
    logic signed [31:0] b;
    logic signed [31:0] t;
    logic [1:0]         status;
  } item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [31:0]              u;
    logic [31:0]              w;
    logic [NDIV-1:0][31:0]    divs;
  } side_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [NDIV-1:0][31:0]    divs;
  } div_side_t;

  typedef struct packed {
    logic        sat;
    logic        neg;
    logic [62:0] m;
  } div_lane_t;

endpackage

@@ rtl/tcf_front.sv @@
// Front end: configuration registers, argument intake and status classification.
module tcf_front import tcf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // arg_in
  input  logic        q_full_i,
  output logic        push_o,
  output item_t       item_o
);

  logic signed [31:0] lower_q, peak_q, upper_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= TCF_LOWER_RST;
      peak_q  <= TCF_PEAK_RST;
      upper_q <= TCF_UPPER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        TCF_REG_LOWER: lower_q <= cfg_data_i;
        TCF_REG_PEAK:  peak_q  <= cfg_data_i;
        TCF_REG_UPPER: upper_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !q_full_i;
  assign push_o        = s_axis_tvalid && !q_full_i;

  always_comb begin
    item_o.a = lower_q;
    item_o.c = peak_q;
    item_o.b = upper_q;
    item_o.t = s_axis_tdata;
    // Bound ordering is checked before the zero argument.
    priority if (!(lower_q < peak_q && peak_q < upper_q)) begin
      item_o.status = TCF_ST_BAD_ORDER;
    end else if (s_axis_tdata == '0) begin
      item_o.status = TCF_ST_ZERO_ARG;
    end else begin
      item_o.status = TCF_ST_OK;
    end
  end

endmodule

@@ rtl/tcf_queue.sv @@
// Short request queue between the front end and the arithmetic pipeline.
module tcf_queue import tcf_pkg::*; #(
  parameter int DEPTH = TCF_QUEUE_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem_q [DEPTH];
  logic [PW-1:0]  wr_q, rd_q;
  logic [CW-1:0]  count_q;
  logic           do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue count exceeds depth");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("request pushed into a full queue");
`endif

endmodule

@@ rtl/tcf_phase.sv @@
// Phase unit: x*t product, reduction modulo 2*pi, quadrant split and rotation CORDIC.
module tcf_phase import tcf_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] x_i,
  input  logic signed [31:0] t_i,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  logic signed [63:0] p_q;
  logic [62:0]        r_q [MOD_STEPS+1];
  logic               n_q [MOD_STEPS+1];
  logic [34:0]        wr_q;
  logic signed [33:0] cx_q [CORDIC_STEPS+1];
  logic signed [33:0] cy_q [CORDIC_STEPS+1];
  logic signed [33:0] cz_q [CORDIC_STEPS+1];
  logic [1:0]         cq_q [CORDIC_STEPS+1];
  logic signed [31:0] cos_q, sin_q;

  localparam logic [34:0] H1 = HALF_PI_Q32;
  localparam logic [34:0] H2 = 35'(HALF_PI_Q32 * 2);
  localparam logic [34:0] H3 = 35'(HALF_PI_Q32 * 3);
  localparam logic [34:0] H4 = 35'(HALF_PI_Q32 * 4);

  logic [34:0]        r_fin;
  logic [34:0]        rem;
  logic [1:0]         quad;
  logic signed [31:0] xc, yc;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q     <= x_i * t_i;
      n_q[0]  <= p_q[63];
      r_q[0]  <= p_q[63] ? 63'(-p_q) : p_q[62:0];
    end
  end

  // One restoring step per stage, largest multiple of 2*pi first.
  for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
    localparam logic [62:0] SUB = 63'(TWO_PI_Q32) << (MOD_STEPS - 1 - j);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[j+1] <= n_q[j];
        r_q[j+1] <= (r_q[j] >= SUB) ? r_q[j] - SUB : r_q[j];
      end
    end
  end

  assign r_fin = r_q[MOD_STEPS][34:0];

  always_comb begin
    priority if (wr_q >= H4) begin
      quad = 2'd0; rem = wr_q - H4;
    end else if (wr_q >= H3) begin
      quad = 2'd3; rem = wr_q - H3;
    end else if (wr_q >= H2) begin
      quad = 2'd2; rem = wr_q - H2;
    end else if (wr_q >= H1) begin
      quad = 2'd1; rem = wr_q - H1;
    end else begin
      quad = 2'd0; rem = wr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // A negative phase wraps to 2*pi minus its reduced magnitude.
      wr_q     <= (n_q[MOD_STEPS] && r_fin != '0) ? TWO_PI_Q32 - r_fin : r_fin;
      cx_q[0]  <= CORDIC_GAIN;
      cy_q[0]  <= '0;
      cz_q[0]  <= $signed({1'b0, rem[34:2]});
      cq_q[0]  <= quad;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic signed [33:0] ANG = $signed({2'b00, ATAN_Q30[i]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cq_q[i+1] <= cq_q[i];
        if (cz_q[i] >= 0) begin
          cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] - ANG;
        end else begin
          cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] + ANG;
        end
      end
    end
  end

  always_comb begin
    if (cx_q[CORDIC_STEPS] > ONE_Q30) xc = 32'(ONE_Q30);
    else if (cx_q[CORDIC_STEPS] < -ONE_Q30) xc = 32'(-ONE_Q30);
    else xc = 32'(cx_q[CORDIC_STEPS]);
    if (cy_q[CORDIC_STEPS] > ONE_Q30) yc = 32'(ONE_Q30);
    else if (cy_q[CORDIC_STEPS] < -ONE_Q30) yc = 32'(-ONE_Q30);
    else yc = 32'(cy_q[CORDIC_STEPS]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unique case (cq_q[CORDIC_STEPS])
        2'd0: begin cos_q <= xc;  sin_q <= yc;  end
        2'd1: begin cos_q <= -yc; sin_q <= xc;  end
        2'd2: begin cos_q <= -xc; sin_q <= -yc; end
        default: begin cos_q <= yc; sin_q <= -xc; end
      endcase
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

@@ rtl/tcf_div.sv @@
// One Q16 division step, floor(m*2^16/d), as a bit-per-stage pipeline on two lanes.
module tcf_div import tcf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [31:0]           d_i,
  input  div_lane_t [1:0]       lane_i,
  input  div_side_t             side_i,
  output div_lane_t [1:0]       lane_o,
  output div_side_t             side_o
);

  logic [31:0] d_q    [DIV_LAT];
  div_side_t   side_q [DIV_LAT];
  div_lane_t   lane_q [DIV_LAT][2];
  logic [31:0] rem_q  [DIV_LAT][2];

  // The quotient reaches 2^63 exactly when the top bits of m are at least d.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q[0]    <= d_i;
      side_q[0] <= side_i;
      for (int l = 0; l < 2; l++) begin
        lane_q[0][l].sat <= lane_i[l].sat || ({16'd0, lane_i[l].m[62:47]} >= d_i);
        lane_q[0][l].neg <= lane_i[l].neg;
        lane_q[0][l].m   <= {lane_i[l].m[46:0], 16'd0};
        rem_q[0][l]      <= {16'd0, lane_i[l].m[62:47]};
      end
    end
  end

  for (genvar s = 1; s < DIV_LAT; s++) begin : g_stage
    logic [32:0] trial [2];
    logic        ge    [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        trial[l] = {rem_q[s-1][l], lane_q[s-1][l].m[62]};
        ge[l]    = trial[l] >= {1'b0, d_q[s-1]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[s]    <= d_q[s-1];
        side_q[s] <= side_q[s-1];
        for (int l = 0; l < 2; l++) begin
          lane_q[s][l].sat <= lane_q[s-1][l].sat;
          lane_q[s][l].neg <= lane_q[s-1][l].neg;
          lane_q[s][l].m   <= {lane_q[s-1][l].m[61:0], ge[l]};
          rem_q[s][l]      <= ge[l] ? 32'(trial[l] - {1'b0, d_q[s-1]}) : trial[l][31:0];
        end
      end
    end
  end

  assign lane_o[0] = lane_q[DIV_LAT-1][0];
  assign lane_o[1] = lane_q[DIV_LAT-1][1];
  assign side_o    = side_q[DIV_LAT-1];

endmodule

@@ rtl/tcf_back.sv @@
// Back end: phase units, numerator, division chain, rounding and the output register.
module tcf_back import tcf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  item_t       q_item_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] out_data_o,
  output logic [1:0]  out_status_o
);

  localparam int VL = PH_LAT + 3 + NDIV * DIV_LAT;

  logic               en;
  logic [VL-1:0]      vld_q;
  logic               out_valid_q;
  logic [31:0]        out_re_q, out_im_q;
  logic [1:0]         out_st_q;

  logic [31:0]        u, v, w, tm, mx, mn;
  logic [1:0]         k;
  side_t              side_d;
  side_t              side_dl [PH_LAT];

  logic signed [31:0] ca, sa, cc, sc, cb, sb;
  logic signed [63:0] pr_q [4];
  logic signed [63:0] nre_q, nim_q;
  side_t              s1_q, s2_q;
  div_lane_t [1:0]    lane_c [NDIV+1];
  div_side_t          dside  [NDIV+1];
  div_lane_t [1:0]    lane0_q;
  div_side_t          dside0_q;

  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en;

  // Divisor order: v is the largest of the bound gaps, |t| enters twice.
  always_comb begin
    u  = q_item_i.b - q_item_i.c;
    v  = q_item_i.b - q_item_i.a;
    w  = q_item_i.c - q_item_i.a;
    tm = q_item_i.t[31] ? 32'(-q_item_i.t) : q_item_i.t;
    mx = (u >= w) ? u : w;
    mn = (u >= w) ? w : u;
    k  = 2'({1'b0, v > tm} + {1'b0, mx > tm} + {1'b0, mn > tm});
    side_d.status = q_item_i.status;
    side_d.u      = u;
    side_d.w      = w;
    unique case (k)
      2'd0: side_d.divs = {mn, mx, v, tm, tm};
      2'd1: side_d.divs = {mn, mx, tm, tm, v};
      2'd2: side_d.divs = {mn, tm, tm, mx, v};
      default: side_d.divs = {tm, tm, mn, mx, v};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_dl[0] <= side_d;
      for (int i = 1; i < PH_LAT; i++) begin
        side_dl[i] <= side_dl[i-1];
      end
    end
  end

  tcf_phase u_ph_a (.clk_i, .en_i(en), .x_i(q_item_i.a), .t_i(q_item_i.t),
                    .cos_o(ca), .sin_o(sa));
  tcf_phase u_ph_c (.clk_i, .en_i(en), .x_i(q_item_i.c), .t_i(q_item_i.t),
                    .cos_o(cc), .sin_o(sc));
  tcf_phase u_ph_b (.clk_i, .en_i(en), .x_i(q_item_i.b), .t_i(q_item_i.t),
                    .cos_o(cb), .sin_o(sb));

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q  <= side_dl[PH_LAT-1];
      pr_q[0] <= 64'($signed({1'b0, side_dl[PH_LAT-1].u}) * ($signed({ca[31], ca}) - cc));
      pr_q[1] <= 64'($signed({1'b0, side_dl[PH_LAT-1].w}) * ($signed({cb[31], cb}) - cc));
      pr_q[2] <= 64'($signed({1'b0, side_dl[PH_LAT-1].u}) * ($signed({sa[31], sa}) - sc));
      pr_q[3] <= 64'($signed({1'b0, side_dl[PH_LAT-1].w}) * ($signed({sb[31], sb}) - sc));
      s2_q  <= s1_q;
      nre_q <= pr_q[0] + pr_q[1];
      nim_q <= pr_q[2] + pr_q[3];
      dside0_q.status <= s2_q.status;
      dside0_q.divs   <= s2_q.divs;
      lane0_q[0].sat  <= 1'b0;
      lane0_q[0].neg  <= nre_q > 0;
      lane0_q[0].m    <= nre_q[63] ? 63'(-nre_q) : nre_q[62:0];
      lane0_q[1].sat  <= 1'b0;
      lane0_q[1].neg  <= nim_q > 0;
      lane0_q[1].m    <= nim_q[63] ? 63'(-nim_q) : nim_q[62:0];
    end
  end

  assign lane_c[0] = lane0_q;
  assign dside[0]  = dside0_q;

  for (genvar d = 0; d < NDIV; d++) begin : g_div
    tcf_div u_div (
      .clk_i,
      .en_i   (en),
      .d_i    (dside[d].divs[d]),
      .lane_i (lane_c[d]),
      .side_i (dside[d]),
      .lane_o (lane_c[d+1]),
      .side_o (dside[d+1])
    );
  end

  // Round half away from zero at Q2.30 and saturate; the sign is that of -N.
  function automatic logic [31:0] finish(div_lane_t l);
    logic [63:0] s;
    logic [48:0] r;
    logic [48:0] nr;
    logic        sat;
    s   = {1'b0, l.m} + 64'd16384;
    r   = s[63:15];
    nr  = -r;
    sat = l.sat || (l.neg && r > 49'h80000000) || (!l.neg && r > 49'h7FFFFFFF);
    if (sat) return l.neg ? 32'h80000000 : 32'h7FFFFFFF;
    return l.neg ? nr[31:0] : r[31:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[VL-2:0], q_valid_i};
      out_valid_q <= vld_q[VL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_st_q <= dside[NDIV].status;
      if (dside[NDIV].status != TCF_ST_OK) begin
        out_re_q <= '0;
        out_im_q <= '0;
      end else begin
        out_re_q <= finish(lane_c[NDIV][0]);
        out_im_q <= finish(lane_c[NDIV][1]);
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = {out_im_q, out_re_q};
  assign out_status_o = out_st_q;

endmodule

@@ rtl/triangular_char_function.sv @@
// Top level of the triangular distribution characteristic function block.
// Usage:
//   Arguments t (signed Q16.16) enter on the s_axis stream, one request per
//   beat. Each request yields one result on the m_axis stream: the real and
//   imaginary parts in signed Q2.30 in tdata and a status code in tuser
//   (0 valid, 1 zero argument, 2 bounds not in order a < c < b; parts zero).
//   The bounds a, c and b are written through cfg_we_i / cfg_idx_i /
//   cfg_data_i (index 0 lower, 1 peak, 2 upper) while no request is in flight.
//   Throughput is one request per clock unless the receiver stalls. After
//   acceptance a request passes through three 57-stage phase units in
//   parallel, three numerator stages, five 64-stage Q16 division steps with
//   one quotient bit per stage after the first, and the output register.
//   Reset clears the queue and all valid flags and loads the bounds with
//   a = 0, c = 0.5, b = 1. When the receiver stalls, the whole pipeline
//   holds; the two-entry input queue then fills and s_axis_tready drops.
module triangular_char_function import tcf_pkg::*; #(
  parameter int QUEUE_DEPTH = TCF_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] arg_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] real_part, [63:32] imag_part
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  logic  q_full, push, q_valid, pop;
  item_t push_item, head_item;

  tcf_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .q_full_i (q_full),
    .push_o   (push),
    .item_o   (push_item)
  );

  tcf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  tcf_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i    (q_valid),
    .q_item_i     (head_item),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_status_o (m_axis_tuser)
  );

`ifndef SYNTHESIS
  a_flag_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != TCF_ST_OK) |-> (m_axis_tdata == '0))
    else $error("flagged result carries nonzero data");
`endif

endmodule
